### hdl/tcc_pkg.sv
// shared constants, codes and types of the text console cursor and scroll engine
package tcc_pkg;

    localparam int ROW_CELLS    = 80;
    localparam int WINDOW_CELLS = 2000;
    localparam int VRAM_CELLS   = 16384;

    localparam int ADDR_W  = 14;
    localparam int CELLS_W = 15;
    localparam int CHAR_W  = 8;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 2;

    localparam int END_W = $clog2(VRAM_CELLS + 1);
    localparam int ROW_W = $clog2(VRAM_CELLS / ROW_CELLS + 1);
    localparam int COL_W = $clog2(ROW_CELLS);

    localparam int WIN_ROWS = WINDOW_CELLS / ROW_CELLS;
    localparam int WIN_COL  = WINDOW_CELLS % ROW_CELLS;

    localparam int CELLS_RESET = 16384;
    localparam int ATTR_RESET  = 7;
    localparam int END_RESET   = (CELLS_RESET < VRAM_CELLS) ? CELLS_RESET : VRAM_CELLS;
    localparam int LIMIT_RESET = (END_RESET > WINDOW_CELLS)
                               ? (END_RESET - WINDOW_CELLS + ROW_CELLS - 1) / ROW_CELLS : 0;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT  = 2'd0,
        MODE_UP   = 2'd1,
        MODE_DOWN = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_BASE  = 2'd0,
        REG_CELLS = 2'd1,
        REG_ATTR  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [END_W-1:0]  region_end;
        logic [ROW_W-1:0]  row_limit;
        logic [CHAR_W-1:0] attr;
        logic              base_load;
    } cfg_t;

endpackage

### hdl/tcc_if.sv
// command and result channels of the console engine

interface tcc_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [tcc_pkg::MODE_W-1:0] mode;
    logic [tcc_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, output mode, output char_code, input ready);
    modport sink   (input valid, input mode, input char_code, output ready);
endinterface

interface tcc_res_if;
    logic                       valid;
    logic                       ready;
    logic                       cell_write;
    logic [tcc_pkg::ADDR_W-1:0] cell_address;
    logic [tcc_pkg::CHAR_W-1:0] cell_char;
    logic [tcc_pkg::CHAR_W-1:0] cell_attr;
    logic [tcc_pkg::ADDR_W-1:0] cursor_pos;
    logic [tcc_pkg::ADDR_W-1:0] window_start;

    modport source (output valid, output cell_write, output cell_address, output cell_char,
                    output cell_attr, output cursor_pos, output window_start, input ready);
    modport sink   (input valid, input cell_write, input cell_address, input cell_char,
                    input cell_attr, input cursor_pos, input window_start, output ready);
endinterface

### hdl/text_console_cursor_scroll_core.sv
// text console engine: cursor, auto-scroll and cell writes for one console region
// a command word is accepted into a hold register and its result is registered once the result register is free
// throughput: one word per cycle, held back only by a stalled result register
// cursor and window are kept as row and column offsets from the base, so no divider sits in the loop
// reset: cursor and window at cell 0, base 0, 16384 cells, attribute 7; no clearing pass
module text_console_cursor_scroll_core (
    input  logic                        clk,
    input  logic                        rst_n,
    tcc_cmd_if.sink                     cmd,
    tcc_res_if.source                   res,
    input  logic                        cfg_we,
    input  logic [tcc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tcc_pkg::CELLS_W-1:0] cfg_wdata
);
    import tcc_pkg::*;

    localparam int D_W = ROW_W + 2;
    localparam int PW  = ADDR_W + ROW_W;

    cfg_t cfg;

    tcc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // window follows the cursor, by whole rows, clamped to the region
    function automatic logic [ROW_W-1:0] follow(input logic [ROW_W-1:0] sr,
                                                input logic [ROW_W-1:0] cr,
                                                input logic [COL_W-1:0] cc,
                                                input logic [ROW_W-1:0] lim);
        logic signed [D_W-1:0] d;
        logic                  ahead;
        logic [ROW_W:0]        tgt;
        logic [ROW_W-1:0]      capped;
        logic [ROW_W-1:0]      s1;
        logic [ROW_W-1:0]      s2;
        d      = $signed({2'b00, cr}) - $signed({2'b00, sr}) - $signed(D_W'(WIN_ROWS));
        ahead  = (d > 0) || ((d == 0) && (cc > COL_W'(WIN_COL)));
        tgt    = {1'b0, cr} + (ROW_W + 1)'(cc >= COL_W'(WIN_COL)) - (ROW_W + 1)'(WIN_ROWS);
        capped = (tgt < {1'b0, lim}) ? tgt[ROW_W-1:0] : lim;
        s1     = (ahead && (capped > sr)) ? capped : sr;
        if (cr < s1)
            s2 = ((cc == '0) && (cr != '0)) ? cr - 1'b1 : cr;
        else
            s2 = s1;
        return s2;
    endfunction

    logic              hold_valid_reg;
    logic [MODE_W-1:0] hold_mode_reg;
    logic [CHAR_W-1:0] hold_char_reg;

    logic [ADDR_W-1:0] cur_reg;
    logic [ROW_W-1:0]  crow_reg;
    logic [COL_W-1:0]  ccol_reg;
    logic [ROW_W-1:0]  srow_reg;

    logic              res_valid_reg;
    logic              wr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CHAR_W-1:0] wch_reg;
    logic [CHAR_W-1:0] wattr_reg;
    logic [ADDR_W-1:0] window_reg;

    logic              slot_free;
    logic              fire;

    logic [ADDR_W-1:0] cur_next;
    logic [ROW_W-1:0]  crow_next;
    logic [COL_W-1:0]  ccol_next;
    logic [ROW_W-1:0]  srow_next;
    logic [ROW_W-1:0]  srow_pre;
    logic              wr_next;
    logic [ADDR_W-1:0] addr_next;
    logic [CHAR_W-1:0] wch_next;
    logic [CHAR_W-1:0] wattr_next;
    logic [PW-1:0]     window_wide;
    logic              col_last;

    assign slot_free = !res_valid_reg || res.ready;
    assign fire      = hold_valid_reg && slot_free;
    assign cmd.ready = !hold_valid_reg || slot_free;
    assign col_last  = (ccol_reg == COL_W'(ROW_CELLS - 1));

    always_comb
    begin
        cur_next   = cur_reg;
        crow_next  = crow_reg;
        ccol_next  = ccol_reg;
        srow_next  = srow_reg;
        wr_next    = 1'b0;
        addr_next  = '0;
        wch_next   = '0;
        wattr_next = '0;
        srow_pre   = follow(srow_reg, crow_reg, ccol_reg, cfg.row_limit);
        unique case (hold_mode_reg)
            MODE_PUT:
            begin
                case (hold_char_reg)
                    CH_NEWLINE:
                    begin
                        if (END_W'(cur_reg) + END_W'(ROW_CELLS) < cfg.region_end)
                        begin
                            cur_next  = cur_reg - ADDR_W'(ccol_reg) + ADDR_W'(ROW_CELLS);
                            crow_next = crow_reg + 1'b1;
                            ccol_next = '0;
                        end
                    end
                    CH_BACKSPACE:
                    begin
                        if (cur_reg > cfg.base)
                        begin
                            cur_next   = cur_reg - 1'b1;
                            wr_next    = 1'b1;
                            addr_next  = cur_reg - 1'b1;
                            wch_next   = CH_SPACE;
                            wattr_next = cfg.attr;
                            if (ccol_reg == '0)
                            begin
                                ccol_next = COL_W'(ROW_CELLS - 1);
                                crow_next = crow_reg - 1'b1;
                            end
                            else
                            begin
                                ccol_next = ccol_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        if (END_W'(cur_reg) + END_W'(1) < cfg.region_end)
                        begin
                            cur_next   = cur_reg + 1'b1;
                            wr_next    = 1'b1;
                            addr_next  = cur_reg;
                            wch_next   = hold_char_reg;
                            wattr_next = cfg.attr;
                            if (col_last)
                            begin
                                ccol_next = '0;
                                crow_next = crow_reg + 1'b1;
                            end
                            else
                            begin
                                ccol_next = ccol_reg + 1'b1;
                            end
                        end
                    end
                endcase
                srow_next = follow(srow_pre, crow_next, ccol_next, cfg.row_limit);
            end
            MODE_UP:
            begin
                if (srow_reg != '0)
                    srow_next = srow_reg - 1'b1;
            end
            MODE_DOWN:
            begin
                if (cfg.row_limit > srow_reg)
                    srow_next = srow_reg + 1'b1;
            end
            MODE_NOP: ;
            default: ;
        endcase
        window_wide = PW'(cfg.base) + PW'(srow_next) * PW'(ROW_CELLS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (cmd.valid && cmd.ready)
            hold_valid_reg <= 1'b1;
        else if (fire)
            hold_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            hold_mode_reg <= cmd.mode;
            hold_char_reg <= cmd.char_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            crow_reg <= '0;
            ccol_reg <= '0;
            srow_reg <= '0;
        end
        else if (cfg.base_load)
        begin
            cur_reg  <= cfg_wdata[ADDR_W-1:0];
            crow_reg <= '0;
            ccol_reg <= '0;
            srow_reg <= '0;
        end
        else if (fire)
        begin
            cur_reg  <= cur_next;
            crow_reg <= crow_next;
            ccol_reg <= ccol_next;
            srow_reg <= srow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (fire)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            wr_reg     <= wr_next;
            addr_reg   <= addr_next;
            wch_reg    <= wch_next;
            wattr_reg  <= wattr_next;
            window_reg <= window_wide[ADDR_W-1:0];
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.cell_write   = wr_reg;
    assign res.cell_address = addr_reg;
    assign res.cell_char    = wch_reg;
    assign res.cell_attr    = wattr_reg;
    assign res.cursor_pos   = cur_reg;
    assign res.window_start = window_reg;

`ifndef NO_ASSERTIONS
    a_base_moves_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.base_load |=> cur_reg == $past(cfg_wdata[ADDR_W-1:0]) && srow_reg == '0)
        else $error("base write did not move cursor and window");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ccol_reg) < ROW_CELLS)
        else $error("cursor column beyond row");

    a_cursor_split: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cur_reg) == int'(cfg.base) + int'(crow_reg) * ROW_CELLS + int'(ccol_reg))
        else $error("cursor address and row and column offsets disagree");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg && !hold_valid_reg || res_valid_reg && $past(cmd.valid))
        else $error("processed word did not reach the result register");
`endif

endmodule

### hdl/tcc_cfg.sv
// configuration registers with region end and last window row worked out on write
module tcc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tcc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tcc_pkg::CELLS_W-1:0] cfg_wdata,
    output tcc_pkg::cfg_t               cfg
);
    import tcc_pkg::*;

    localparam int SUM_W       = CELLS_W + 1;
    localparam int SPAN_W      = END_W;
    localparam int RECIP_SHIFT = SPAN_W + $clog2(ROW_CELLS);
    localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + ROW_CELLS - 1) / ROW_CELLS;
    localparam int RECIP_W     = RECIP_SHIFT - $clog2(ROW_CELLS) + 1;
    localparam int PROD_W      = SPAN_W + RECIP_W;

    logic [ADDR_W-1:0]  base_reg;
    logic [CELLS_W-1:0] cells_reg;
    logic [CHAR_W-1:0]  attr_reg;
    logic [END_W-1:0]   end_reg;
    logic [ROW_W-1:0]   limit_reg;

    logic [ADDR_W-1:0]  base_next;
    logic [CELLS_W-1:0] cells_next;
    logic [CHAR_W-1:0]  attr_next;
    logic [SUM_W-1:0]   sum;
    logic [END_W-1:0]   end_next;
    logic [END_W-1:0]   len;
    logic [SPAN_W-1:0]  span;
    logic [PROD_W-1:0]  prod;
    logic [ROW_W-1:0]   limit_next;

    always_comb
    begin
        base_next  = base_reg;
        cells_next = cells_reg;
        attr_next  = attr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE:  base_next  = cfg_wdata[ADDR_W-1:0];
                REG_CELLS: cells_next = cfg_wdata;
                REG_ATTR:  attr_next  = cfg_wdata[CHAR_W-1:0];
                default:   ;
            endcase
        end
    end

    // region end clamped to video memory, then ceil of the spare rows below the window
    always_comb
    begin
        sum      = SUM_W'(base_next) + SUM_W'(cells_next);
        end_next = (sum > SUM_W'(VRAM_CELLS)) ? END_W'(VRAM_CELLS) : sum[END_W-1:0];
        len      = end_next - END_W'(base_next);
        span     = (len > END_W'(WINDOW_CELLS))
                 ? len - END_W'(WINDOW_CELLS) + END_W'(ROW_CELLS - 1) : '0;
        prod     = PROD_W'(span) * PROD_W'(RECIP);
        limit_next = prod[RECIP_SHIFT +: ROW_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            cells_reg <= CELLS_W'(CELLS_RESET);
            attr_reg  <= CHAR_W'(ATTR_RESET);
            end_reg   <= END_W'(END_RESET);
            limit_reg <= ROW_W'(LIMIT_RESET);
        end
        else if (cfg_we)
        begin
            base_reg  <= base_next;
            cells_reg <= cells_next;
            attr_reg  <= attr_next;
            end_reg   <= end_next;
            limit_reg <= limit_next;
        end
    end

    assign cfg.base       = base_reg;
    assign cfg.region_end = end_reg;
    assign cfg.row_limit  = limit_reg;
    assign cfg.attr       = attr_reg;
    assign cfg.base_load  = cfg_we && (cfg_index == REG_BASE);

`ifndef NO_ASSERTIONS
    a_end_above_base: assert property (@(posedge clk) disable iff (!rst_n)
        int'(end_reg) >= int'(base_reg) && int'(end_reg) <= VRAM_CELLS)
        else $error("region end outside base and video memory");

    a_limit_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(end_reg) - int'(base_reg) > WINDOW_CELLS) |->
        (int'(limit_reg) * ROW_CELLS >= int'(end_reg) - int'(base_reg) - WINDOW_CELLS &&
         int'(limit_reg) * ROW_CELLS <  int'(end_reg) - int'(base_reg) - WINDOW_CELLS
                                        + ROW_CELLS))
        else $error("last window row does not match region length");

    a_base_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.base_load |=> base_reg == $past(cfg_wdata[ADDR_W-1:0]))
        else $error("base write lost");
`endif

endmodule

### tb/tb_text_console_cursor_scroll_core.sv
// testbench for the text console engine: predicted cell writes, cursor and window per word
`timescale 1ns / 100ps

module tb_text_console_cursor_scroll_core;

    import tcc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic              cell_write;
        logic [ADDR_W-1:0] cell_address;
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attr;
        logic [ADDR_W-1:0] cursor_pos;
        logic [ADDR_W-1:0] window_start;
    } console_word_t;

    class console_scoreboard;
        logic [ADDR_W-1:0]  base_cell;
        logic [CELLS_W-1:0] region_cells;
        logic [CHAR_W-1:0]  attr_byte;
        logic [ADDR_W-1:0]  cursor_cell;
        logic [ADDR_W-1:0]  window_cell;
        console_word_t      expected_words[$];
        int                 mismatches;

        function new();
            base_cell    = '0;
            region_cells = CELLS_W'(CELLS_RESET);
            attr_byte    = CHAR_W'(ATTR_RESET);
            cursor_cell  = '0;
            window_cell  = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CELLS_W-1:0] value);
            case (idx)
                REG_BASE:
                begin
                    base_cell   = value[ADDR_W-1:0];
                    cursor_cell = value[ADDR_W-1:0];
                    window_cell = value[ADDR_W-1:0];
                end
                REG_CELLS: region_cells = value;
                REG_ATTR:  attr_byte = value[CHAR_W-1:0];
                default: ;
            endcase
        endfunction

        function int region_end();
            int e;
            e = int'(base_cell) + int'(region_cells);
            return (e > VRAM_CELLS) ? VRAM_CELLS : e;
        endfunction

        function void window_up(int rows);
            int s;
            int lo;
            int room;
            s    = int'(window_cell);
            lo   = int'(base_cell);
            room = 0;
            if (s > lo)
                room = (s - lo + ROW_CELLS - 1) / ROW_CELLS;
            if (rows > room)
                rows = room;
            s = s - rows * ROW_CELLS;
            if (s < lo)
                s = lo;
            window_cell = ADDR_W'(s);
        endfunction

        function void window_down(int rows);
            int s;
            int e;
            int room;
            s    = int'(window_cell);
            e    = region_end();
            room = 0;
            if (s + WINDOW_CELLS < e)
                room = (e - s - WINDOW_CELLS + ROW_CELLS - 1) / ROW_CELLS;
            if (rows > room)
                rows = room;
            window_cell = ADDR_W'(s + rows * ROW_CELLS);
        endfunction

        function void track_cursor();
            int c;
            int s;
            c = int'(cursor_cell);
            s = int'(window_cell);
            if (s + WINDOW_CELLS < c)
                window_down((c - (s + WINDOW_CELLS)) / ROW_CELLS + 1);
            s = int'(window_cell);
            if (c < s)
                window_up((s - c) / ROW_CELLS + 1);
        endfunction

        function void note_command(mode_t m, logic [CHAR_W-1:0] ch);
            console_word_t w;
            int c;
            int lo;
            int e;
            w = '0;
            case (m)
                MODE_PUT:
                begin
                    lo = int'(base_cell);
                    e  = region_end();
                    c  = int'(cursor_cell);
                    track_cursor();
                    if (ch == CH_NEWLINE)
                    begin
                        if (c < e - ROW_CELLS)
                            c = lo + ROW_CELLS * ((c - lo) / ROW_CELLS + 1);
                    end
                    else if (ch == CH_BACKSPACE)
                    begin
                        if (c > lo)
                        begin
                            c = c - 1;
                            w.cell_write   = 1'b1;
                            w.cell_address = ADDR_W'(c);
                            w.cell_char    = CH_SPACE;
                            w.cell_attr    = attr_byte;
                        end
                    end
                    else if (c < e - 1)
                    begin
                        w.cell_write   = 1'b1;
                        w.cell_address = ADDR_W'(c);
                        w.cell_char    = ch;
                        w.cell_attr    = attr_byte;
                        c = c + 1;
                    end
                    cursor_cell = ADDR_W'(c);
                    track_cursor();
                end
                MODE_UP:   window_up(1);
                MODE_DOWN: window_down(1);
                default: ;
            endcase
            w.cursor_pos   = cursor_cell;
            w.window_start = window_cell;
            expected_words.push_back(w);
        endfunction

        function void check_word(console_word_t got);
            console_word_t want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: we=%0d addr=%0d ch=%02h attr=%02h cur=%0d win=%0d",
                             got.cell_write, got.cell_address, got.cell_char, got.cell_attr,
                             got.cursor_pos, got.window_start);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected we=%0d addr=%0d ch=%02h attr=%02h cur=%0d win=%0d",
                                 want.cell_write, want.cell_address, want.cell_char,
                                 want.cell_attr, want.cursor_pos, want.window_start);
                        $display("          actual   we=%0d addr=%0d ch=%02h attr=%02h cur=%0d win=%0d",
                                 got.cell_write, got.cell_address, got.cell_char,
                                 got.cell_attr, got.cursor_pos, got.window_start);
                    end
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_index;
    logic [CELLS_W-1:0]  cfg_wdata;

    int          snd_idle_pct;
    int          rcv_idle_pct;
    bit          hold_request;
    int unsigned cycle_count;

    console_scoreboard console_sb = new();

    tcc_cmd_if cmd_bus ();
    tcc_res_if res_bus ();

    text_console_cursor_scroll_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic offer_word(mode_t m, logic [CHAR_W-1:0] ch);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.mode      <= m;
        cmd_bus.char_code <= ch;
        @(posedge clk);
        while (cmd_bus.ready !== 1'b1)
            @(posedge clk);
        console_sb.note_command(m, ch);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CELLS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        console_sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        while (console_sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly random character bytes with newlines, backspaces, window moves and no-op words mixed in
    task automatic random_words(int count, int newline_pct);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < newline_pct)
                offer_word(MODE_PUT, CH_NEWLINE);
            else if (r < newline_pct + 10)
                offer_word(MODE_PUT, CH_BACKSPACE);
            else if (r < newline_pct + 25)
                offer_word(mode_t'($urandom_range(3, 1)), CHAR_W'($urandom_range(255)));
            else
                offer_word(MODE_PUT, CHAR_W'($urandom_range(255)));
        end
    endtask

    initial
    begin
        console_word_t got;
        int hold_left;
        hold_left = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            begin
                got = {res_bus.cell_write, res_bus.cell_address, res_bus.cell_char,
                       res_bus.cell_attr, res_bus.cursor_pos, res_bus.window_start};
                console_sb.check_word(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin
        hold_request       = 1'b0;
        snd_idle_pct       = 31;
        rcv_idle_pct       = 75;
        rst_n             <= 1'b0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.mode      <= MODE_NOP;
        cmd_bus.char_code <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_BASE;
        cfg_wdata         <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset region: backspace at the start, edge bytes, window moves at the base
        offer_word(MODE_PUT, CH_BACKSPACE);
        offer_word(MODE_PUT, 8'h41);
        offer_word(MODE_PUT, 8'h00);
        offer_word(MODE_PUT, 8'hFF);
        offer_word(MODE_PUT, 8'h7F);
        offer_word(MODE_PUT, CH_BACKSPACE);
        offer_word(MODE_PUT, CH_NEWLINE);
        offer_word(MODE_UP, 8'hFF);
        offer_word(MODE_DOWN, 8'h00);
        offer_word(MODE_DOWN, 8'hAA);
        offer_word(MODE_UP, 8'h55);
        offer_word(MODE_NOP, 8'hFF);

        // region at the top of memory: last cell, last row, scroll limits
        wait_idle();
        write_reg(REG_BASE, CELLS_W'(VRAM_CELLS - 1));
        write_reg(REG_CELLS, CELLS_W'(WINDOW_CELLS));
        write_reg(REG_ATTR, CELLS_W'(255));
        offer_word(MODE_PUT, 8'h55);
        offer_word(MODE_PUT, CH_NEWLINE);
        offer_word(MODE_PUT, CH_BACKSPACE);
        offer_word(MODE_DOWN, 8'h00);
        offer_word(MODE_UP, 8'h00);
        offer_word(MODE_NOP, 8'h00);

        wait_idle();
        write_reg(REG_BASE, '0);
        write_reg(REG_CELLS, CELLS_W'(VRAM_CELLS));
        write_reg(REG_ATTR, CELLS_W'(255));
        random_words(130, 25);

        // shrink the region under the cursor
        wait_idle();
        write_reg(REG_CELLS, CELLS_W'(WINDOW_CELLS));
        write_reg(REG_ATTR, '0);
        random_words(130, 20);

        snd_idle_pct = 75;
        rcv_idle_pct = 31;
        wait_idle();
        write_reg(REG_BASE, CELLS_W'(14000));
        write_reg(REG_CELLS, CELLS_W'(VRAM_CELLS));
        write_reg(REG_ATTR, CELLS_W'(8'h5A));
        random_words(140, 30);

        wait_idle();
        write_reg(REG_BASE, CELLS_W'(12000));
        write_reg(REG_CELLS, CELLS_W'(3000));
        write_reg(REG_ATTR, CELLS_W'(8'hA5));
        random_words(130, 25);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        wait_idle();
        write_reg(REG_BASE, CELLS_W'(5));
        write_reg(REG_CELLS, CELLS_W'(VRAM_CELLS));
        write_reg(REG_ATTR, CELLS_W'(8'h1E));
        hold_request = 1'b1;
        random_words(200, 40);

        wait_idle();
        write_reg(REG_CELLS, CELLS_W'(2500));
        write_reg(REG_ATTR, CELLS_W'(8'hC3));
        random_words(100, 25);

        wait_idle();
        repeat (10) @(posedge clk);
        if (console_sb.mismatches == 0 && console_sb.expected_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hdl/tcc_pkg.sv
hdl/tcc_if.sv
hdl/tcc_cfg.sv
hdl/text_console_cursor_scroll_core.sv
tb/tb_text_console_cursor_scroll_core.sv
